@@ src/assert_macros.svh @@
// Assertion macros used by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CSVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define CSVT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ src/csvt_pkg.sv @@
// Types and constants for the CSV field tokenizer.
`default_nettype none
package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_END   = 8'h00;

    typedef enum logic [2:0] {
        KIND_DATA            = 3'd0,
        KIND_FIELD_END       = 3'd1,
        KIND_RECORD_END      = 3'd2,
        KIND_TEXT_END_RECORD = 3'd3,
        KIND_TEXT_END_EMPTY  = 3'd4,
        KIND_QUOTE_ERROR     = 3'd5
    } kind_t;

    typedef struct packed {
        logic in_quoted_field;
        logic quote_pending;
        logic cr_pending;
        logic has_content;
        logic record_open;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{default: 1'b0};

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]   count;
        result_t      r0;
        result_t      r1;
        parse_state_t next_state;
    } decode_t;

endpackage
`default_nettype wire

@@ src/csvt_decode.sv @@
// Per-byte decision logic: results and next parse state for one text byte.
`default_nettype none
module csvt_decode (
    input  wire csvt_pkg::parse_state_t state,
    input  wire logic [7:0]             text_byte,
    output csvt_pkg::decode_t           dec
);
    import csvt_pkg::*;

    typedef struct packed {
        parse_state_t st;
        logic         vld;
        kind_t        kind;
        logic [7:0]   data;
    } plain_t;

    function automatic plain_t plain_byte(parse_state_t s, logic [7:0] c);
        plain_t p;
        p.st   = s;
        p.vld  = 1'b0;
        p.kind = KIND_DATA;
        p.data = 8'h00;
        if (c == CH_QUOTE && !s.has_content) begin
            p.st.in_quoted_field = 1'b1;
            p.st.has_content     = 1'b1;
        end else if (c == CH_COMMA) begin
            p.vld  = 1'b1;
            p.kind = KIND_FIELD_END;
            p.st.has_content = 1'b0;
            p.st.record_open = 1'b1;
        end else if (c == CH_LF) begin
            p.vld  = 1'b1;
            p.kind = KIND_RECORD_END;
            p.st.has_content = 1'b0;
            p.st.record_open = 1'b0;
        end else if (c == CH_END) begin
            p.vld  = 1'b1;
            p.kind = (!s.record_open && !s.has_content) ? KIND_TEXT_END_EMPTY
                                                        : KIND_TEXT_END_RECORD;
            p.st   = STATE_RESET;
        end else if (c == CH_CR) begin
            p.st.cr_pending = 1'b1;
        end else begin
            p.vld  = 1'b1;
            p.kind = KIND_DATA;
            p.data = c;
            p.st.has_content = 1'b1;
        end
        return p;
    endfunction

    parse_state_t st_pre;
    plain_t       pl;
    logic         use_plain;
    logic         pre_vld;
    kind_t        pre_kind;
    logic [7:0]   pre_data;

    always_comb
    begin
        st_pre    = state;
        use_plain = 1'b0;
        pre_vld   = 1'b0;
        pre_kind  = KIND_DATA;
        pre_data  = 8'h00;
        if (state.in_quoted_field) begin
            if (state.quote_pending) begin
                st_pre.quote_pending = 1'b0;
                if (text_byte == CH_QUOTE) begin
                    pre_vld  = 1'b1;
                    pre_data = CH_QUOTE;
                end else begin
                    st_pre.in_quoted_field = 1'b0;
                    use_plain = 1'b1;
                end
            end else if (text_byte == CH_QUOTE) begin
                st_pre.quote_pending = 1'b1;
            end else if (text_byte == CH_END) begin
                pre_vld  = 1'b1;
                pre_kind = KIND_QUOTE_ERROR;
                st_pre   = STATE_RESET;
            end else begin
                pre_vld  = 1'b1;
                pre_data = text_byte;
                st_pre.has_content = 1'b1;
            end
        end else begin
            use_plain = 1'b1;
            if (state.cr_pending) begin
                st_pre.cr_pending = 1'b0;
                if (text_byte != CH_LF) begin
                    pre_vld  = 1'b1;
                    pre_data = CH_CR;
                    st_pre.has_content = 1'b1;
                end
            end
        end
    end

    assign pl = plain_byte(st_pre, text_byte);

    always_comb
    begin
        dec            = '0;
        dec.next_state = use_plain ? pl.st : st_pre;
        if (pre_vld && use_plain && pl.vld) begin
            dec.count = 2'd2;
            dec.r0    = '{kind: pre_kind, data: pre_data, last: 1'b0};
            dec.r1    = '{kind: pl.kind, data: pl.data, last: 1'b1};
        end else if (pre_vld) begin
            dec.count = 2'd1;
            dec.r0    = '{kind: pre_kind, data: pre_data, last: 1'b1};
        end else if (use_plain && pl.vld) begin
            dec.count = 2'd1;
            dec.r0    = '{kind: pl.kind, data: pl.data, last: 1'b1};
        end
    end

endmodule
`default_nettype wire

@@ src/csvt_out_buf.sv @@
// Two-entry result buffer between the decode logic and the output channel.
`default_nettype none
`include "assert_macros.svh"
module csvt_out_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [1:0]           push_count,
    input  wire csvt_pkg::result_t    push_r0,
    input  wire csvt_pkg::result_t    push_r1,
    input  wire logic                 push,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output csvt_pkg::result_t         head
);
    import csvt_pkg::*;

    result_t    slot_reg [2];
    result_t    slot_next [2];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] cnt_pop;
    logic       pop;
    logic [2:0] fill;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = slot_reg[0];
    assign pop       = out_valid && !out_stall;
    assign cnt_pop   = cnt_reg - {1'b0, pop};
    assign fill      = {1'b0, cnt_pop} + {1'b0, push_count};
    assign room      = (fill <= 3'd2);

    always_comb
    begin
        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_next     = cnt_pop;
        if (push && push_count != 2'd0) begin
            slot_next[cnt_pop[0]] = push_r0;
            if (push_count == 2'd2) begin
                slot_next[1] = push_r1;
            end
            cnt_next = fill[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    `CSVT_NEVER(a_cnt_range, cnt_reg == 2'd3, "result buffer count out of range")
    `CSVT_NEVER(a_push_room, push && !room, "push into full result buffer")
    `CSVT_ASSERT(a_pair_fits, push && push_count == 2'd2 |-> cnt_pop == 2'd0, "two results need an empty buffer")

endmodule
`default_nettype wire

@@ src/csv_field_tokenizer.sv @@
// Top level of the streaming CSV field tokenizer.
// Accepts one text byte per cycle, unless in_stall is high, into an input register; the next
// cycle the byte is decoded against the parse flags and its zero, one or two results go into a
// two-entry result buffer that drives the output channel. Bytes that give one result or none
// sustain one byte per cycle while out_stall is low; a byte that gives two results (a
// dropped-back CR followed by another result) goes into the buffer as a pair, and the input
// register holds until the result buffer has room for them.
`default_nettype none
module csv_field_tokenizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] text_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      kind,
    output logic [7:0]      field_byte,
    output logic            last
);
    import csvt_pkg::*;

    logic         in_vld_reg;
    logic         in_vld_next;
    logic [7:0]   in_byte_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    decode_t      dec;
    logic         room;
    logic         commit;
    logic         accept;
    result_t      head;

    csvt_decode u_decode (
        .state     (state_reg),
        .text_byte (in_byte_reg),
        .dec       (dec)
    );

    csvt_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (dec.count),
        .push_r0    (dec.r0),
        .push_r1    (dec.r1),
        .push       (commit),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head       (head)
    );

    assign commit   = in_vld_reg && room;
    assign in_stall = in_vld_reg && !commit;
    assign accept   = in_valid && !in_stall;

    assign in_vld_next = accept ? 1'b1 : (commit ? 1'b0 : in_vld_reg);
    assign state_next  = commit ? dec.next_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
            state_reg  <= STATE_RESET;
        end else begin
            in_vld_reg <= in_vld_next;
            state_reg  <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_byte_reg <= text_byte;
        end
    end

    assign kind       = head.kind;
    assign field_byte = head.data;
    assign last       = head.last;

endmodule
`default_nettype wire
